FILE: rtl/obs_pkg.sv
`timescale 1ns / 1ps
// Package for the ordered byte set: capacity, widths, action codes,
// the queued command record and the back-end state type. No dependencies.
package obs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 8;
    localparam int POS_W    = 4;
    localparam int ECOUNT_W = 5;

    // Action codes as they arrive on the request channel.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_CONTAINS = 3'd2,
        ACT_GET      = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    // Decoded operation carried from the front end to the back end.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_CONTAINS,
        OP_GET,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } t_state;

endpackage

FILE: rtl/obs_req_if.sv
`timescale 1ns / 1ps
// Request channel of the ordered byte set: valid/ready plus one request beat.
// Depends on nothing.
interface obs_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] value;
    logic [3:0] position;

    modport source (output valid, output action, output value, output position,
                    input ready);
    modport sink   (input valid, input action, input value, input position,
                    output ready);
endinterface

FILE: rtl/obs_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the ordered byte set: valid/ready plus one result beat.
// Depends on nothing.
interface obs_rsp_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic       full_refused;
    logic [7:0] read_value;
    logic [4:0] entry_count;

    modport source (output valid, output success, output full_refused,
                    output read_value, output entry_count, input ready);
    modport sink   (input valid, input success, input full_refused,
                    input read_value, input entry_count, output ready);
endinterface

FILE: rtl/obs_front.sv
`timescale 1ns / 1ps
// Front end: accepts request beats, decodes the action and holds them in a
// two-entry command queue. Depends on obs_pkg and obs_req_if.
module obs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obs_req_if.sink       i_req,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output obs_pkg::t_cmd o_q_cmd
);
    import obs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Decode the action into an operation; unused codes become no-ops.
    always_comb begin
        w_cmd.value    = i_req.value;
        w_cmd.position = i_req.position;
        case (i_req.action)
            ACT_ADD:      w_cmd.op = OP_ADD;
            ACT_REMOVE:   w_cmd.op = OP_REMOVE;
            ACT_CONTAINS: w_cmd.op = OP_CONTAINS;
            ACT_GET:      w_cmd.op = OP_GET;
            ACT_CLEAR:    w_cmd.op = OP_CLEAR;
            default:      w_cmd.op = OP_NONE;
        endcase
    end

    assign i_req.ready = (r_fill != 2'd2);
    assign o_q_valid   = (r_fill != 2'd0);
    assign o_q_cmd     = r_slot[r_rd_ptr];
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

FILE: rtl/obs_back.sv
`timescale 1ns / 1ps
// Back end: entry cells with per-cell compare, count, a three-state sequencer
// and the result register. Depends on obs_pkg and obs_rsp_if.
module obs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  obs_pkg::t_cmd i_q_cmd,
    obs_rsp_if.source     o_rsp
);
    import obs_pkg::*;

    t_state              r_state,  n_state;
    t_cmd                r_cmd,    n_cmd;
    logic [CAPACITY-1:0] r_match,  n_match;
    logic [VALUE_W-1:0]  r_cell    [CAPACITY];
    logic [VALUE_W-1:0]  n_cell    [CAPACITY];
    logic [CNT_W-1:0]    r_count,  n_count;
    logic                r_out_valid, n_out_valid;
    logic                r_success,   n_success;
    logic                r_refused,   n_refused;
    logic [VALUE_W-1:0]  r_read,      n_read;
    logic [ECOUNT_W-1:0] r_ecount,    n_ecount;
    logic                w_found;
    logic [CAPACITY-1:0] w_after;

    // Cells at or past the first match; these shift down on a remove.
    always_comb begin
        logic v_acc;
        v_acc = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            v_acc      = v_acc | r_match[i];
            w_after[i] = v_acc;
        end
        w_found = v_acc;
    end

    always_comb begin
        logic               v_succ;
        logic               v_ref;
        logic [VALUE_W-1:0] v_read;
        v_succ      = 1'b0;
        v_ref       = 1'b0;
        v_read      = '0;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_match     = r_match;
        n_cell      = r_cell;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_success   = r_success;
        n_refused   = r_refused;
        n_read      = r_read;
        n_ecount    = r_ecount;
        o_q_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    n_match[i] = (r_cell[i] == r_cmd.value) && (CNT_W'(i) < r_count);
                end
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    case (r_cmd.op)
                        OP_ADD: begin
                            if (!w_found) begin
                                if (r_count >= CNT_W'(CAPACITY)) begin
                                    v_ref = 1'b1;
                                end else begin
                                    for (int i = 0; i < CAPACITY; i++) begin
                                        if (CNT_W'(i) == r_count) begin
                                            n_cell[i] = r_cmd.value;
                                        end
                                    end
                                    n_count = r_count + CNT_W'(1);
                                    v_succ  = 1'b1;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (w_found) begin
                                for (int i = 0; i < CAPACITY - 1; i++) begin
                                    if (w_after[i]) begin
                                        n_cell[i] = r_cell[i+1];
                                    end
                                end
                                n_count = r_count - CNT_W'(1);
                                v_succ  = 1'b1;
                            end
                        end
                        OP_CONTAINS: begin
                            v_succ = w_found;
                        end
                        OP_GET: begin
                            for (int i = 0; i < CAPACITY; i++) begin
                                if (i == int'(r_cmd.position) && CNT_W'(i) < r_count) begin
                                    v_read = r_cell[i];
                                    v_succ = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            v_succ  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_success   = v_succ;
                    n_refused   = v_ref;
                    n_read      = v_read;
                    n_ecount    = ECOUNT_W'(n_count);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_match   <= n_match;
        r_cell    <= n_cell;
        r_success <= n_success;
        r_refused <= n_refused;
        r_read    <= n_read;
        r_ecount  <= n_ecount;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.success      = r_success;
    assign o_rsp.full_refused = r_refused;
    assign o_rsp.read_value   = r_read;
    assign o_rsp.entry_count  = r_ecount;

endmodule

FILE: rtl/ordered_byte_set.sv
`timescale 1ns / 1ps
// Ordered byte set: up to CAPACITY distinct bytes kept in insertion order.
// An accepted request beat waits in the command queue; the back-end sequencer
// takes one request at a time through its states (dequeue, parallel compare of
// all cells, commit into the result register) before it dequeues the next.
// Reset (synchronous, active low) empties the store, command queue and result
// register; cell contents are left as they are and are only read below the count.
module ordered_byte_set (
    input  logic      i_clk,
    input  logic      i_rst_n,
    obs_req_if.sink   i_req,
    obs_rsp_if.source o_rsp
);
    import obs_pkg::*;

    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    // Front end: take request beats whenever the command queue has room,
    // decode them and hold them until the back end is free.
    obs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_cmd   (w_q_cmd)
    );

    // Back end: compare against every cell, then update the cells and the
    // count and load the result register; hold in commit while the result
    // register is still occupied.
    obs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_cmd   (w_q_cmd),
        .o_rsp     (o_rsp)
    );

    // A refused add never reports success and only happens at full count.
    a_refused_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.full_refused
            |-> !o_rsp.success && o_rsp.entry_count == ECOUNT_W'(CAPACITY))
        else $error("refused add without full store");

    // A nonzero read value only comes from a successful get.
    a_read_success : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.read_value != '0 |-> o_rsp.success)
        else $error("read value without success");

    // Reported count never passes the capacity.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.entry_count <= ECOUNT_W'(CAPACITY))
        else $error("entry count past capacity");

    // A result beat that is not taken stays offered with its payload unchanged.
    a_result_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable({o_rsp.success,
            o_rsp.full_refused, o_rsp.read_value, o_rsp.entry_count}))
        else $error("result beat changed while waiting");

endmodule
